>>> sv/qfbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the quadratic form bin evaluator.
// No dependencies.

package qfbe_pkg;

    localparam int MAX_PARAMS_DEF = 32;
    localparam int MAX_BINS_DEF   = 4096;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 5;
    localparam int POSITION_W  = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_SET_PARAM = 1'b0;
    localparam logic CMD_TERM      = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_ONE_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_TWO_EN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 3'd4;

    typedef struct packed {
        logic                      command;
        logic [INDEX_W-1:0]        param_index;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        first_param;
        logic [INDEX_W-1:0]        second_param;
        logic                      quadratic;
        logic                      last_term;
        logic signed [VALUE_W-1:0] scale_one;
        logic signed [VALUE_W-1:0] scale_two;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] bin_value;
        logic [POSITION_W-1:0]     bin_position;
        logic                      overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] coeff;
        logic signed [VALUE_W-1:0] p1;
        logic signed [VALUE_W-1:0] p2;
        logic                      quadratic;
        logic                      last_term;
        logic signed [VALUE_W-1:0] scale_one;
        logic signed [VALUE_W-1:0] scale_two;
    } t_term;

    typedef struct packed {
        logic                  zero_start;
        logic                  scale_one_en;
        logic                  scale_two_en;
        logic [CFG_DATA_W-1:0] rows;
        logic [CFG_DATA_W-1:0] row_length;
    } t_cfg;

endpackage

>>> sv/qfbe_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
// No dependencies.

module qfbe_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> sv/qfbe_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, applies parameter writes, looks up term parameters.
// Depends on qfbe_pkg and qfbe_ram.

module qfbe_front #(
    parameter int MAX_PARAMS = qfbe_pkg::MAX_PARAMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  qfbe_pkg::t_in_item        i_item,
    input  logic [qfbe_pkg::QCNT_W-1:0] i_q_count,
    output logic                      o_term_valid,
    output qfbe_pkg::t_term           o_term
);
    import qfbe_pkg::*;

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    logic                      w_accept;
    logic [QCNT_W:0]           w_used;
    logic                      w_wr_ok;
    logic                      w_first_ok;
    logic                      w_second_ok;
    logic [VALUE_W-1:0]        w_rd_a;
    logic [VALUE_W-1:0]        w_rd_b;

    logic                      r_f1_valid;
    logic signed [VALUE_W-1:0] r_coeff;
    logic                      r_quad;
    logic                      r_last;
    logic signed [VALUE_W-1:0] r_s1;
    logic signed [VALUE_W-1:0] r_s2;
    logic                      r_first_ok;
    logic                      r_second_ok;

    assign w_used   = (QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(r_f1_valid);
    assign o_full   = (w_used >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign w_accept = i_push && !o_full;

    assign w_wr_ok     = (32'(i_item.param_index) < 32'(MAX_PARAMS));
    assign w_first_ok  = (32'(i_item.first_param) < 32'(MAX_PARAMS));
    assign w_second_ok = (32'(i_item.second_param) < 32'(MAX_PARAMS));

    qfbe_ram #(
        .DATA_W (VALUE_W),
        .DEPTH  (MAX_PARAMS)
    ) u_param_ram (
        .i_clk     (i_clk),
        .i_we      (w_accept && (i_item.command == CMD_SET_PARAM) && w_wr_ok),
        .i_waddr   (AW'(i_item.param_index)),
        .i_wdata   (i_item.value),
        .i_raddr_a (AW'(i_item.first_param)),
        .i_raddr_b (AW'(i_item.second_param)),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= w_accept && (i_item.command == CMD_TERM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_coeff     <= i_item.value;
            r_quad      <= i_item.quadratic;
            r_last      <= i_item.last_term;
            r_s1        <= i_item.scale_one;
            r_s2        <= i_item.scale_two;
            r_first_ok  <= w_first_ok;
            r_second_ok <= w_second_ok;
        end
    end

    assign o_term_valid       = r_f1_valid;
    assign o_term.coeff       = r_coeff;
    assign o_term.p1          = r_first_ok ? $signed(w_rd_a) : '0;
    assign o_term.p2          = r_second_ok ? $signed(w_rd_b) : '0;
    assign o_term.quadratic   = r_quad;
    assign o_term.last_term   = r_last;
    assign o_term.scale_one   = r_s1;
    assign o_term.scale_two   = r_s2;

endmodule

>>> sv/qfbe_queue.sv
`timescale 1ns / 1ps
// Short term queue between front end and back end.
// Depends on qfbe_pkg.

module qfbe_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  qfbe_pkg::t_term             i_term,
    input  logic                        i_pop,
    output qfbe_pkg::t_term             o_term,
    output logic                        o_empty,
    output logic [qfbe_pkg::QCNT_W-1:0] o_count
);
    import qfbe_pkg::*;

    t_term              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_term;
        end
    end

    assign o_term  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("term queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("term queue underflow");

endmodule

>>> sv/qfbe_back.sv
`timescale 1ns / 1ps
// Back end: shared multiplier sequencer, bin accumulator, scaling, position, result register.
// Depends on qfbe_pkg.

module qfbe_back #(
    parameter int MAX_BINS  = qfbe_pkg::MAX_BINS_DEF,
    parameter int FRAC_BITS = qfbe_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qfbe_pkg::t_cfg      i_cfg,
    input  logic                i_q_empty,
    input  qfbe_pkg::t_term     i_q_term,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output qfbe_pkg::t_out_item o_item
);
    import qfbe_pkg::*;

    localparam int GEO_W = $clog2(MAX_BINS + 1);
    localparam int CNT_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int POS_W = (CNT_W + GEO_W + 1 > POSITION_W) ? CNT_W + GEO_W + 1 : POSITION_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_NARROW = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    localparam logic [1:0] PH_TERM   = 2'd0;
    localparam logic [1:0] PH_QUAD   = 2'd1;
    localparam logic [1:0] PH_SCALE1 = 2'd2;
    localparam logic [1:0] PH_SCALE2 = 2'd3;

    localparam logic signed [47:0] ONE_FIXED = 48'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] S48_MAX = (66'sd1 <<< 47) - 66'sd1;
    localparam logic signed [65:0] S48_MIN = -(66'sd1 <<< 47);
    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] x);
        logic signed [31:0] v;
        if (x > S32_MAX) begin
            v = 32'sh7FFF_FFFF;
        end else if (x < S32_MIN) begin
            v = 32'sh8000_0000;
        end else begin
            v = 32'(x);
        end
        return v;
    endfunction

    function automatic logic f_ovf32(input logic signed [65:0] x);
        return (x > S32_MAX) || (x < S32_MIN);
    endfunction

    logic [2:0]                r_state,    n_state;
    logic [1:0]                r_phase,    n_phase;
    logic signed [31:0]        r_op_a,     n_op_a;
    logic signed [31:0]        r_op_b,     n_op_b;
    logic signed [63:0]        r_prod,     n_prod;
    logic signed [31:0]        r_p2,       n_p2;
    logic signed [31:0]        r_s1,       n_s1;
    logic signed [31:0]        r_s2,       n_s2;
    logic                      r_quad,     n_quad;
    logic                      r_last,     n_last;
    logic signed [47:0]        r_sum,      n_sum;
    logic                      r_bin_open, n_bin_open;
    logic signed [31:0]        r_result,   n_result;
    logic                      r_sat,      n_sat;
    logic [CNT_W-1:0]          r_row,      n_row;
    logic [CNT_W-1:0]          r_col,      n_col;
    t_out_item                 r_out,      n_out;
    logic                      r_out_valid, n_out_valid;

    logic signed [63:0]        w_shift;
    logic signed [31:0]        w_shift_sat;
    logic                      w_shift_ovf;
    logic signed [65:0]        w_acc;
    logic signed [47:0]        w_acc_sat;
    logic signed [31:0]        w_sum_sat;
    logic                      w_sum_ovf;
    logic [GEO_W-1:0]          w_m;
    logic [GEO_W-1:0]          w_n;
    logic                      w_transpose;
    logic [POS_W-1:0]          w_pos;
    logic [GEO_W-1:0]          w_col_inc;
    logic [GEO_W-1:0]          w_row_inc;
    logic                      w_emit_ok;

    assign w_shift     = r_prod >>> FRAC_BITS;
    assign w_shift_sat = f_sat32(66'(w_shift));
    assign w_shift_ovf = f_ovf32(66'(w_shift));
    assign w_acc       = 66'(r_sum) + 66'(w_shift);
    assign w_acc_sat   = (w_acc > S48_MAX) ? 48'(S48_MAX) :
                         (w_acc < S48_MIN) ? 48'(S48_MIN) : 48'(w_acc);
    assign w_sum_sat   = f_sat32(66'(r_sum));
    assign w_sum_ovf   = f_ovf32(66'(r_sum));

    always_comb begin
        if (i_cfg.rows == '0) begin
            w_m = GEO_W'(1);
        end else if (32'(i_cfg.rows) > 32'(MAX_BINS)) begin
            w_m = GEO_W'(MAX_BINS);
        end else begin
            w_m = GEO_W'(i_cfg.rows);
        end
        if (i_cfg.row_length == '0) begin
            w_n = GEO_W'(1);
        end else if (32'(i_cfg.row_length) > 32'(MAX_BINS)) begin
            w_n = GEO_W'(MAX_BINS);
        end else begin
            w_n = GEO_W'(i_cfg.row_length);
        end
    end

    assign w_transpose = (w_m > GEO_W'(1));
    assign w_pos = w_transpose ?
        POS_W'(r_col) * POS_W'(w_m) + POS_W'(r_row) :
        POS_W'(r_row) * POS_W'(w_n) + POS_W'(r_col);
    assign w_col_inc = GEO_W'(r_col) + GEO_W'(1);
    assign w_row_inc = GEO_W'(r_row) + GEO_W'(1);
    assign w_emit_ok = !r_out_valid || i_pop;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_op_a      = r_op_a;
        n_op_b      = r_op_b;
        n_prod      = r_prod;
        n_p2        = r_p2;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_quad      = r_quad;
        n_last      = r_last;
        n_sum       = r_sum;
        n_bin_open  = r_bin_open;
        n_result    = r_result;
        n_sat       = r_sat;
        n_row       = r_row;
        n_col       = r_col;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_q_pop     = 1'b0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_op_a  = i_q_term.coeff;
                    n_op_b  = i_q_term.p1;
                    n_p2    = i_q_term.p2;
                    n_s1    = i_q_term.scale_one;
                    n_s2    = i_q_term.scale_two;
                    n_quad  = i_q_term.quadratic;
                    n_last  = i_q_term.last_term;
                    n_phase = PH_TERM;
                    n_state = S_MUL;
                    if (!r_bin_open) begin
                        n_sum      = i_cfg.zero_start ? '0 : ONE_FIXED;
                        n_bin_open = 1'b1;
                    end
                end
            end
            S_MUL: begin
                n_prod  = r_op_a * r_op_b;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                case (r_phase)
                    PH_TERM, PH_QUAD: begin
                        if (r_phase == PH_TERM && r_quad) begin
                            n_op_a  = w_shift_sat;
                            n_op_b  = r_p2;
                            n_phase = PH_QUAD;
                            n_state = S_MUL;
                        end else begin
                            n_sum   = w_acc_sat;
                            n_state = r_last ? S_NARROW : S_IDLE;
                        end
                    end
                    PH_SCALE1: begin
                        n_result = w_shift_sat;
                        n_sat    = r_sat || w_shift_ovf;
                        if (i_cfg.scale_two_en) begin
                            n_op_a  = w_shift_sat;
                            n_op_b  = r_s2;
                            n_phase = PH_SCALE2;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    PH_SCALE2: begin
                        n_result = w_shift_sat;
                        n_sat    = r_sat || w_shift_ovf;
                        n_state  = S_EMIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_NARROW: begin
                n_result = w_sum_sat;
                n_sat    = w_sum_ovf;
                if (i_cfg.scale_one_en) begin
                    n_op_a  = w_sum_sat;
                    n_op_b  = r_s1;
                    n_phase = PH_SCALE1;
                    n_state = S_MUL;
                end else if (i_cfg.scale_two_en) begin
                    n_op_a  = w_sum_sat;
                    n_op_b  = r_s2;
                    n_phase = PH_SCALE2;
                    n_state = S_MUL;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit_ok) begin
                    n_out.bin_value    = r_result;
                    n_out.bin_position = w_pos[POSITION_W-1:0];
                    n_out.overflow     = r_sat;
                    n_out_valid        = 1'b1;
                    n_bin_open         = 1'b0;
                    n_sum              = '0;
                    n_state            = S_IDLE;
                    if (w_col_inc >= w_n) begin
                        n_col = '0;
                        if (w_row_inc >= w_m) begin
                            n_row = '0;
                        end else begin
                            n_row = CNT_W'(w_row_inc);
                        end
                    end else begin
                        n_col = CNT_W'(w_col_inc);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_open  <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bin_open  <= n_bin_open;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_op_a   <= n_op_a;
        r_op_b   <= n_op_b;
        r_prod   <= n_prod;
        r_p2     <= n_p2;
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_quad   <= n_quad;
        r_last   <= n_last;
        r_sum    <= n_sum;
        r_result <= n_result;
        r_sat    <= n_sat;
        r_out    <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_emit_ok) |=> r_out_valid)
        else $error("bin result lost at emit");

    a_quad_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_phase == PH_QUAD) |-> r_quad)
        else $error("second product on a linear term");

    a_narrow_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NARROW) |-> r_bin_open)
        else $error("bin closed without an open sum");

endmodule

>>> sv/quadratic_form_bin_evaluator.sv
`timescale 1ns / 1ps
// Top level of the quadratic form bin evaluator: configuration registers and
// front end, term queue and back end. Depends on qfbe_pkg, qfbe_front, qfbe_queue, qfbe_back.
//
// Usage:
//   Input channel: drive i_in_item and raise push; a beat is taken at a clock
//   edge with push high and full low. Command 0 writes a parameter slot at
//   once; command 1 is a coefficient term, looked up in the parameter store
//   and queued for the back end.
//   Result channel: while empty is low, o_out_item holds the oldest bin
//   result; pop takes it. One result per term marked last.
//   Configuration: i_cfg_we, i_cfg_index, i_cfg_data write one register per
//   cycle; write only while no bin is in flight.
//   Sequencing: the back end shares one 32x32 multiplier over a sequencer:
//   a linear term passes through idle, multiply and shift, a quadratic term
//   multiplies and shifts twice; a last term adds a narrow step, a multiply
//   and shift per enabled scale factor and an emit step. From accept to a
//   result a term passes the registered parameter lookup, the queue and these steps.
//   The front end keeps taking beats into a 4-deep queue while the back end
//   works or a result waits; full rises when the queue is taken up.
//   Reset: clears bin state and position counters, restores the register
//   defaults (one row, row length 4096); parameter slots hold no value until written.

module quadratic_form_bin_evaluator #(
    parameter int MAX_PARAMS = qfbe_pkg::MAX_PARAMS_DEF,
    parameter int MAX_BINS   = qfbe_pkg::MAX_BINS_DEF,
    parameter int FRAC_BITS  = qfbe_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  qfbe_pkg::t_in_item              i_in_item,
    output logic                            empty,
    input  logic                            pop,
    output qfbe_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_we,
    input  logic [qfbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qfbe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qfbe_pkg::*;

    t_cfg               r_cfg;
    logic               w_term_valid;
    t_term              w_term;
    t_term              w_q_term;
    logic               w_q_empty;
    logic               w_q_pop;
    logic [QCNT_W-1:0]  w_q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_start   <= 1'b0;
            r_cfg.scale_one_en <= 1'b0;
            r_cfg.scale_two_en <= 1'b0;
            r_cfg.rows         <= CFG_DATA_W'(1);
            r_cfg.row_length   <= CFG_DATA_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ZERO_START:   r_cfg.zero_start   <= i_cfg_data[0];
                CFG_SCALE_ONE_EN: r_cfg.scale_one_en <= i_cfg_data[0];
                CFG_SCALE_TWO_EN: r_cfg.scale_two_en <= i_cfg_data[0];
                CFG_ROWS:         r_cfg.rows         <= i_cfg_data;
                CFG_ROW_LENGTH:   r_cfg.row_length   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    qfbe_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_item       (i_in_item),
        .i_q_count    (w_q_count),
        .o_term_valid (w_term_valid),
        .o_term       (w_term)
    );

    qfbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_term_valid),
        .i_term  (w_term),
        .i_pop   (w_q_pop),
        .o_term  (w_q_term),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    qfbe_back #(
        .MAX_BINS  (MAX_BINS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_q_term  (w_q_term),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule
